// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: hw/rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Constants, types and codes of the fit-policy partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

   localparam int NUM_BLOCKS = 8;
   localparam int SIZE_BITS  = 16;
   localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int IDX_W      = 3;
   localparam int AMT_W      = 16;
   localparam int SUM_W      = 19;
   localparam int ACC_W      = SIZE_BITS + BLK_W;
   localparam int SAT_W      = (ACC_W > SUM_W) ? ACC_W : SUM_W;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [BLK_W-1:0]     blk_type;
   typedef logic [ACC_W-1:0]     acc_type;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_RESTORE = 2'd1,
      MODE_ALLOC   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2,
      POL_WORST = 2'd3
   } policy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RESTORE,
      ST_SCAN,
      ST_UPDATE,
      ST_SUM
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Fixed-partition allocator: load, restore and allocate under a selectable
// fit policy, reporting grant, chosen partition and total free space.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  req       start & !busy             mode, block_index, amount
//  rsp       strobe (one cycle)        granted, chosen_block, free_total
//  csr       valid & ready             fit_policy
//
//  Load writes one entry and then sums; restore copies the table and then
//  sums; allocate scans, updates the chosen entry and then sums; unused mode
//  only sums. Each pass reads one partition entry per cycle: the fit scan or
//  restore copy, then the shared adder for the sum; the result strobe follows.
//  Reset clears all partition sizes, the next-fit pointer and the policy.
//  busy is high from the accepted start until the result strobe; the
//  receiver cannot stall, so the strobe is never held.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [1:0]                req_mode,
   input  wire logic [fpba_pkg::IDX_W-1:0] req_block_index,
   input  wire logic [fpba_pkg::AMT_W-1:0] req_amount,
   output logic                           rsp_valid,
   output logic                           rsp_granted,
   output logic [fpba_pkg::IDX_W-1:0]     rsp_chosen_block,
   output logic [fpba_pkg::SUM_W-1:0]     rsp_free_total,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_fit_policy
);
   import fpba_pkg::*;

   `include "assert_macros.svh"

   state_type  state_ff, state_in;
   policy_type policy_ff;
   logic [1:0] mode_ff;
   logic [IDX_W-1:0] idx_ff;
   size_type   amt_ff;
   blk_type    step_ff, step_in;
   blk_type    ptr_ff, ptr_in;
   blk_type    pick_ff, pick_in;
   logic       found_ff, found_in;
   size_type   best_ff, best_in;
   acc_type    acc_ff, acc_in;
   logic       granted_ff, granted_in;
   size_type   remaining_ff [NUM_BLOCKS];
   size_type   initial_ff   [NUM_BLOCKS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_granted_ff, rsp_granted_in;
   logic [IDX_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [SUM_W-1:0] rsp_total_ff, rsp_total_in;

   logic       rem_we, init_we;
   blk_type    rem_wa;
   size_type   rem_wd;
   blk_type    rd_addr;
   size_type   rem_rd;
   logic [BLK_W:0] wrap_sum;
   logic       last_step, fits, take;
   logic [SAT_W-1:0] acc_wide;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_free_total   = rsp_total_ff;

   // Circular scan address for next fit.
   always_comb begin
      wrap_sum = {1'b0, ptr_ff} + {1'b0, step_ff};
      if (wrap_sum >= (BLK_W+1)'(NUM_BLOCKS)) begin
         wrap_sum = wrap_sum - (BLK_W+1)'(NUM_BLOCKS);
      end
   end

   assign last_step = (step_ff == BLK_W'(NUM_BLOCKS - 1));
   assign rd_addr   = (state_ff == ST_SCAN && policy_ff == POL_NEXT) ?
                      wrap_sum[BLK_W-1:0] : step_ff;
   assign rem_rd    = remaining_ff[rd_addr];
   assign fits      = (rem_rd >= amt_ff);

   always_comb begin
      case (policy_ff)
         POL_BEST:  take = fits && (!found_ff || rem_rd <= best_ff);
         POL_WORST: take = fits && (!found_ff || rem_rd >= best_ff);
         default:   take = fits && !found_ff;
      endcase
   end

   always_comb begin
      acc_wide = SAT_W'(acc_ff + ACC_W'(rem_rd));
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      ptr_in         = ptr_ff;
      pick_in        = pick_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      acc_in         = acc_ff;
      granted_in     = granted_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_total_in   = rsp_total_ff;
      rem_we         = 1'b0;
      init_we        = 1'b0;
      rem_wa         = step_ff;
      rem_wd         = initial_ff[step_ff];

      unique case (state_ff)
         ST_IDLE: begin
            step_in  = '0;
            found_in = 1'b0;
            acc_in   = '0;
            if (start) begin
               unique case (req_mode)
                  MODE_LOAD:    state_in = ST_LOAD;
                  MODE_RESTORE: state_in = ST_RESTORE;
                  MODE_ALLOC:   state_in = ST_SCAN;
                  default:      state_in = ST_SUM;
               endcase
               granted_in = (req_mode == MODE_LOAD) || (req_mode == MODE_RESTORE);
            end
         end
         ST_LOAD: begin
            if (int'(idx_ff) < NUM_BLOCKS) begin
               rem_we  = 1'b1;
               init_we = 1'b1;
               rem_wa  = BLK_W'(idx_ff);
               rem_wd  = amt_ff;
            end
            state_in = ST_SUM;
         end
         ST_RESTORE: begin
            // copy one entry per cycle
            rem_we  = 1'b1;
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step) begin
               ptr_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in = 1'b1;
               pick_in  = rd_addr;
               best_in  = rem_rd;
            end
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (found_ff) begin
               rem_we     = 1'b1;
               rem_wa     = pick_ff;
               rem_wd     = best_ff - amt_ff;
               granted_in = 1'b1;
               if (policy_ff == POL_NEXT) begin
                  ptr_in = pick_ff;
               end
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in  = acc_ff + ACC_W'(rem_rd);
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_chosen_in  = (mode_ff == MODE_ALLOC && found_ff) ?
                                IDX_W'(pick_ff) : '0;
               rsp_total_in   = (acc_wide > SAT_W'(SUM_MAX)) ?
                                SUM_MAX : SUM_W'(acc_wide);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FIRST;
         ptr_ff       <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         granted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            remaining_ff[b] <= '0;
            initial_ff[b]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         granted_ff   <= granted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= policy_type'(csr_fit_policy);
         end
         if (rem_we) begin
            remaining_ff[rem_wa] <= rem_wd;
         end
         if (init_we) begin
            initial_ff[rem_wa] <= rem_wd;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff <= req_mode;
         idx_ff  <= req_block_index;
         amt_ff  <= SIZE_BITS'(req_amount);
      end
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      acc_ff         <= acc_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_total_ff   <= rsp_total_in;
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_sum_ends, clock, reset, state_ff == ST_SUM && last_step, rsp_valid && !busy)
   `ASSERT_SAME(a_deny_zero, clock, reset, rsp_valid && !rsp_granted, rsp_chosen_block == '0)
   `ASSERT_NEXT(a_ptr_hold, clock, reset, state_ff == ST_SCAN || state_ff == ST_SUM, $stable(ptr_ff))

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fit-policy partition allocator. A driver
// feeds loads, restores, allocations, unused-mode items and policy writes
// from a backlog. A monitor predicts every accepted item, including grant,
// chosen partition and free total, and compares each result strobe in order.
// ----------------------------------------------------------------------------

module tb_top;
   import fpba_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 1000;

   typedef enum logic [1:0] {
      JOB_REQ,
      JOB_CSR,
      JOB_SETTLE
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [1:0]       mode;
      logic [IDX_W-1:0] blk;
      logic [AMT_W-1:0] amount;
      logic [1:0]       policy;
      logic             calm;
   } job_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] chosen_block;
      logic [SUM_W-1:0] free_total;
   } alloc_report_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [1:0]          req_mode         = '0;
   logic [IDX_W-1:0]    req_block_index  = '0;
   logic [AMT_W-1:0]    req_amount       = '0;
   logic                rsp_valid;
   logic                rsp_granted;
   logic [IDX_W-1:0]    rsp_chosen_block;
   logic [SUM_W-1:0]    rsp_free_total;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_fit_policy   = '0;

   job_type             request_backlog[$];
   alloc_report_type    predicted_reports[$];
   int                  requests_sent    = 0;
   int                  reports_seen     = 0;
   int                  mismatches       = 0;
   int                  gap_left         = 0;
   int                  stall_cycles     = 0;
   logic                calm_fill        = 1'b0;
   logic                calm_now         = 1'b0;

   // Mirror of the partition table
   size_type            part_left [NUM_BLOCKS];
   size_type            part_init [NUM_BLOCKS];
   blk_type             rover;
   policy_type          fit_pol;

   fit_policy_block_allocator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_block_index  (req_block_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_free_total   (rsp_free_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_fit_policy   (csr_fit_policy)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic alloc_report_type apply_partition_item(input logic [1:0] mode,
         input logic [IDX_W-1:0] blk, input size_type amt);
      alloc_report_type rep;
      blk_type          scan;
      blk_type          pick;
      logic             found;
      logic [SUM_W:0]   total;
      rep   = '0;
      found = 1'b0;
      pick  = '0;
      total = '0;
      case (mode)
         MODE_LOAD: begin
            part_init[blk] = amt;
            part_left[blk] = amt;
            rep.granted    = 1'b1;
         end
         MODE_RESTORE: begin
            part_left   = part_init;
            rover       = '0;
            rep.granted = 1'b1;
         end
         MODE_ALLOC: begin
            // first and next fit take the first hit in scan order
            scan = (fit_pol == POL_NEXT) ? rover : '0;
            for (int n = 0; n < NUM_BLOCKS; n++) begin
               if (part_left[scan] >= amt) begin
                  case (fit_pol)
                     POL_BEST:  if (!found || part_left[scan] <= part_left[pick]) pick = scan;
                     POL_WORST: if (!found || part_left[scan] >= part_left[pick]) pick = scan;
                     default:   if (!found) pick = scan;
                  endcase
                  found = 1'b1;
               end
               scan = scan + 1'b1;
            end
            if (found) begin
               part_left[pick] = part_left[pick] - amt;
               if (fit_pol == POL_NEXT)
                  rover = pick;
               rep.granted      = 1'b1;
               rep.chosen_block = pick;
            end
         end
         default: ;
      endcase
      for (int b = 0; b < NUM_BLOCKS; b++)
         total = total + part_left[b];
      rep.free_total = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
      return rep;
   endfunction

   task automatic push_req(input logic [1:0] mode, input logic [IDX_W-1:0] blk,
         input logic [AMT_W-1:0] amount);
      job_type j;
      j        = '0;
      j.kind   = JOB_REQ;
      j.mode   = mode;
      j.blk    = blk;
      j.amount = amount;
      j.calm   = calm_fill;
      request_backlog.push_back(j);
   endtask

   task automatic push_csr(input policy_type pol);
      job_type j;
      j        = '0;
      j.kind   = JOB_CSR;
      j.policy = pol;
      j.calm   = calm_fill;
      request_backlog.push_back(j);
   endtask

   task automatic push_settle();
      job_type j;
      j      = '0;
      j.kind = JOB_SETTLE;
      j.calm = calm_fill;
      request_backlog.push_back(j);
   endtask

   function automatic logic [AMT_W-1:0] pick_request();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return AMT_W'($urandom_range(0, 65535));
         default: return AMT_W'($urandom_range(0, 65535) >> $urandom_range(1, 15));
      endcase
   endfunction

   // Driver: one launch per step, start/csr_valid assigned once at the end
   always @(posedge clock) begin
      logic    go_start;
      logic    go_csr;
      job_type head;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         gap_left   = 0;
      end else begin
         go_start = start;
         go_csr   = csr_valid;
         if (start && !busy) begin
            go_start      = 1'b0;
            requests_sent = requests_sent + 1;
            if (!calm_now && $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 11);
         end
         if (csr_valid && csr_ready)
            go_csr = 1'b0;
         if (!go_start && !go_csr && request_backlog.size() != 0) begin
            head = request_backlog[0];
            if (gap_left != 0 && !head.calm) begin
               gap_left = gap_left - 1;
            end else begin
               gap_left = 0;
               case (head.kind)
                  JOB_REQ: begin
                     void'(request_backlog.pop_front());
                     go_start         = 1'b1;
                     calm_now         = head.calm;
                     req_mode        <= head.mode;
                     req_block_index <= head.blk;
                     req_amount      <= head.amount;
                  end
                  JOB_CSR: begin
                     // hold the write until every report is back
                     if (requests_sent == reports_seen) begin
                        void'(request_backlog.pop_front());
                        go_csr          = 1'b1;
                        csr_fit_policy <= head.policy;
                     end
                  end
                  default: begin
                     if (requests_sent == reports_seen)
                        void'(request_backlog.pop_front());
                  end
               endcase
            end
         end
         start     <= go_start;
         csr_valid <= go_csr;
      end
   end

   // Monitor: check reports first, then predict the item taken at this edge
   always @(posedge clock) begin
      alloc_report_type want;
      if (reset) begin
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            part_left[b] = '0;
            part_init[b] = '0;
         end
         rover         = '0;
         fit_pol       = POL_FIRST;
         reports_seen <= 0;
      end else begin
         if (rsp_valid) begin
            reports_seen <= reports_seen + 1;
            if (predicted_reports.size() == 0) begin
               $error("report with nothing predicted: granted %0d block %0d free %0d",
                      rsp_granted, rsp_chosen_block, rsp_free_total);
               mismatches = mismatches + 1;
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_granted);
                  mismatches = mismatches + 1;
               end
               if (rsp_chosen_block !== want.chosen_block) begin
                  $error("chosen_block: expected %0d, got %0d",
                         want.chosen_block, rsp_chosen_block);
                  mismatches = mismatches + 1;
               end
               if (rsp_free_total !== want.free_total) begin
                  $error("free_total: expected %0d, got %0d",
                         want.free_total, rsp_free_total);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (csr_valid && csr_ready)
            fit_pol = policy_type'(csr_fit_policy);
         if (start && !busy)
            predicted_reports.push_back(apply_partition_item(req_mode, req_block_index,
                                                             req_amount));
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $error("no transfer for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      policy_type pol;
      int         r;

      // Directed part: empty table, extremes, every policy and tie breaks
      push_csr(POL_FIRST);
      push_req(MODE_ALLOC, 3'd0, 16'd0);
      push_req(MODE_ALLOC, 3'd7, 16'd1);
      push_req(MODE_UNUSED, 3'd7, 16'hFFFF);
      push_req(MODE_LOAD, 3'd0, 16'd100);
      push_req(MODE_LOAD, 3'd1, 16'hFFFF);
      push_req(MODE_LOAD, 3'd2, 16'd0);
      push_req(MODE_LOAD, 3'd3, 16'd300);
      push_req(MODE_LOAD, 3'd4, 16'd300);
      push_req(MODE_LOAD, 3'd5, 16'hFFFF);
      push_req(MODE_LOAD, 3'd6, 16'd5);
      push_req(MODE_LOAD, 3'd7, 16'd1);
      push_req(MODE_ALLOC, 3'd0, 16'd200);
      push_req(MODE_ALLOC, 3'd0, 16'hFFFF);
      push_csr(POL_BEST);
      push_req(MODE_ALLOC, 3'd0, 16'd300);
      push_req(MODE_ALLOC, 3'd0, 16'd0);
      push_req(MODE_RESTORE, 3'd0, 16'd0);
      push_csr(POL_NEXT);
      push_req(MODE_ALLOC, 3'd0, 16'd50);
      push_req(MODE_ALLOC, 3'd0, 16'd80);
      push_req(MODE_ALLOC, 3'd0, 16'hFFFF);
      push_req(MODE_ALLOC, 3'd0, 16'hFFFF);
      push_req(MODE_ALLOC, 3'd0, 16'd0);
      push_csr(POL_WORST);
      push_req(MODE_ALLOC, 3'd0, 16'd1);
      push_settle();

      // Random phases, one policy per phase; the last phase runs without gaps
      for (int ph = 0; ph < 10; ph++) begin
         calm_fill = (ph == 9) || ($urandom_range(0, 3) == 0);
         pol       = (ph < 4) ? policy_type'(ph) : policy_type'($urandom_range(0, 3));
         push_csr(pol);
         if ($urandom_range(0, 1) == 0) begin
            for (int b = 0; b < NUM_BLOCKS; b++)
               push_req(MODE_LOAD, IDX_W'(b), AMT_W'($urandom_range(0, 65535)));
            push_req(MODE_RESTORE, IDX_W'($urandom_range(0, 7)), pick_request());
         end
         for (int k = 0; k < 120; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
               push_req(MODE_LOAD, IDX_W'($urandom_range(0, 7)),
                        ($urandom_range(0, 2) == 0) ? pick_request()
                                                    : AMT_W'($urandom_range(0, 65535)));
            else if (r < 20)
               push_req(MODE_RESTORE, IDX_W'($urandom_range(0, 7)), pick_request());
            else if (r < 96)
               push_req(MODE_ALLOC, IDX_W'($urandom_range(0, 7)), pick_request());
            else
               push_req(MODE_UNUSED, IDX_W'($urandom_range(0, 7)),
                        AMT_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 59) == 0)
               push_settle();
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (request_backlog.size() != 0 || start || csr_valid
             || requests_sent != reports_seen);
      repeat (24) @(posedge clock);

      if (predicted_reports.size() != 0) begin
         $error("%0d predicted reports never arrived", predicted_reports.size());
         mismatches = mismatches + 1;
      end
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
